// File: hw/rtl/fbpa_pkg.sv
// fbpa_pkg: shared types and constants of the fixed block pool allocator
// field widths, operation and status codes, register indexes, controller/datapath structs
// no dependencies

package fbpa_pkg;

   localparam int DATA_W      = 32;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int SHIFT_W     = 4;
   localparam int COUNT_W     = 9;
   localparam int CSR_INDEX_W = 2;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_INIT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FREE    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd3;

   // result codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ALIGN  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_UNINIT = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT = 2'd2;

   // register reset values and legal block size range
   localparam logic [DATA_W-1:0]  BASE_RESET  = 32'd0;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd3;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd1;
   localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd3;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd12;

   // controller to datapath
   typedef struct packed {
      logic accept;   // latch the request
      logic commit;   // execute the latched request and load the result register
      logic walk;     // write one link entry of the init sweep
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic init_go;    // latched request is an init with a legal configuration
      logic walk_last;  // current sweep entry is the final block
      logic out_free;   // result register can take a new result this cycle
   } sts_type;

endpackage

// File: hw/rtl/fbpa_ctrl.sv
// fbpa_ctrl: sequencing state machine of the block pool allocator
// issues accept, commit and sweep commands to fbpa_datapath
// depends on fbpa_pkg

module fbpa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fbpa_pkg::sts_type sts,
   output fbpa_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;

   always_comb begin
      state_in     = state_ff;
      req_ready_in = req_ready_ff;
      cmd.accept   = 1'b0;
      cmd.commit   = 1'b0;
      cmd.walk     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid && req_ready_ff;
            if (cmd.accept) begin
               state_in     = ST_EXEC;
               req_ready_in = 1'b0;
            end
         end
         ST_EXEC: begin
            cmd.commit = sts.out_free;
            if (sts.out_free) begin
               if (sts.init_go) begin
                  state_in = ST_WALK;
               end else begin
                  state_in     = ST_IDLE;
                  req_ready_in = 1'b1;
               end
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.walk_last) begin
               state_in     = ST_IDLE;
               req_ready_in = 1'b1;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            req_ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

endmodule

// File: hw/rtl/fbpa_datapath.sv
// fbpa_datapath: request latch, configuration, pool state, link memory and result register
// carries out the commands of fbpa_ctrl and reports status back
// depends on fbpa_pkg

module fbpa_datapath #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fbpa_pkg::cmd_type                   cmd,
   output fbpa_pkg::sts_type                   sts,
   input  logic [fbpa_pkg::KIND_W-1:0]         req_kind,
   input  logic [fbpa_pkg::DATA_W-1:0]         req_address,
   input  logic                                csr_write_enable,
   input  logic [fbpa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fbpa_pkg::DATA_W-1:0]         csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fbpa_pkg::STATUS_W-1:0]       rsp_status,
   output logic [fbpa_pkg::DATA_W-1:0]         rsp_block_address
);

   localparam int IDX_W  = $clog2(MAX_BLOCKS + 1);
   localparam int MEM_AW = $clog2(MAX_BLOCKS);
   localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(MAX_BLOCKS);
   localparam logic [fbpa_pkg::DATA_W-1:0] MAX_WIDE = fbpa_pkg::DATA_W'(MAX_BLOCKS);

   // configuration registers
   logic [fbpa_pkg::DATA_W-1:0]  cfg_base_ff;
   logic [fbpa_pkg::SHIFT_W-1:0] cfg_shift_ff;
   logic [fbpa_pkg::COUNT_W-1:0] cfg_count_ff;

   // pool geometry latched at init
   logic [fbpa_pkg::DATA_W-1:0]  pool_base_ff;
   logic [fbpa_pkg::SHIFT_W-1:0] pool_shift_ff;
   logic [fbpa_pkg::COUNT_W-1:0] pool_count_ff;
   logic [fbpa_pkg::DATA_W-1:0]  pool_region_ff;
   logic [fbpa_pkg::DATA_W-1:0]  pool_mask_ff;

   // pool state
   logic [IDX_W-1:0] head_ff, head_in;
   logic             init_ff, init_in;
   logic [MEM_AW-1:0] walk_cnt_ff;

   // latched request
   logic [fbpa_pkg::KIND_W-1:0] req_kind_ff;
   logic [fbpa_pkg::DATA_W-1:0] req_address_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [fbpa_pkg::STATUS_W-1:0] rsp_status_ff, status_in;
   logic [fbpa_pkg::DATA_W-1:0]   rsp_address_ff, address_in;

   // link memory
   logic [IDX_W-1:0]  link_mem [MAX_BLOCKS];
   logic [IDX_W-1:0]  link_rd_ff;
   logic [MEM_AW-1:0] rd_addr;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_waddr;
   logic [IDX_W-1:0]  mem_wdata;

   logic [fbpa_pkg::DATA_W-1:0] offset;
   logic [fbpa_pkg::DATA_W-1:0] block_index;
   logic [fbpa_pkg::DATA_W-1:0] alloc_address;
   logic [IDX_W-1:0]            link_next;
   logic                        count_ok;
   logic                        shift_ok;
   logic                        init_go;
   logic                        push;

   assign count_ok = (cfg_count_ff != '0)
                     && (fbpa_pkg::DATA_W'(cfg_count_ff) <= MAX_WIDE);
   assign shift_ok = (cfg_shift_ff >= fbpa_pkg::SHIFT_MIN)
                     && (cfg_shift_ff <= fbpa_pkg::SHIFT_MAX);

   assign offset        = req_address_ff - pool_base_ff;
   assign block_index   = offset >> pool_shift_ff;
   assign alloc_address = pool_base_ff + (fbpa_pkg::DATA_W'(head_ff) << pool_shift_ff);
   assign link_next     = (link_rd_ff > NULL_IDX) ? NULL_IDX : link_rd_ff;

   always_comb begin
      status_in  = fbpa_pkg::STATUS_OK;
      address_in = '0;
      head_in    = head_ff;
      init_in    = init_ff;
      init_go    = 1'b0;
      push       = 1'b0;
      if (req_kind_ff == fbpa_pkg::KIND_INIT) begin
         if (!count_ok) begin
            status_in = fbpa_pkg::STATUS_RANGE;
         end else if (!shift_ok) begin
            status_in = fbpa_pkg::STATUS_ALIGN;
         end else begin
            init_go = 1'b1;
            head_in = '0;
            init_in = 1'b1;
         end
      end else if (!init_ff) begin
         status_in = fbpa_pkg::STATUS_UNINIT;
      end else begin
         case (req_kind_ff)
            fbpa_pkg::KIND_ALLOC: begin
               if (head_ff >= NULL_IDX) begin
                  status_in = fbpa_pkg::STATUS_EMPTY;
               end else begin
                  address_in = alloc_address;
                  head_in    = link_next;
               end
            end
            fbpa_pkg::KIND_FREE: begin
               if (offset >= pool_region_ff) begin
                  status_in = fbpa_pkg::STATUS_RANGE;
               end else if ((offset & pool_mask_ff) != '0) begin
                  status_in = fbpa_pkg::STATUS_ALIGN;
               end else if (block_index >= MAX_WIDE) begin
                  status_in = fbpa_pkg::STATUS_RANGE;
               end else begin
                  push    = 1'b1;
                  head_in = block_index[IDX_W-1:0];
               end
            end
            default: begin
               init_in = 1'b0;
               head_in = NULL_IDX;
            end
         endcase
      end
   end

   // status back to the controller
   assign sts.init_go   = init_go;
   assign sts.walk_last = (fbpa_pkg::DATA_W'(walk_cnt_ff) + 1) == fbpa_pkg::DATA_W'(pool_count_ff);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // single write port: sweep entry or freed block
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = walk_cnt_ff;
      mem_wdata = sts.walk_last ? NULL_IDX : (IDX_W'(walk_cnt_ff) + IDX_W'(1));
      if (cmd.walk) begin
         mem_we = 1'b1;
      end else if (cmd.commit && push) begin
         mem_we    = 1'b1;
         mem_waddr = block_index[MEM_AW-1:0];
         mem_wdata = head_ff;
      end
   end

   // read port follows the head
   assign rd_addr = (head_ff >= NULL_IDX) ? '0 : head_ff[MEM_AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      link_rd_ff <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_base_ff    <= fbpa_pkg::BASE_RESET;
         cfg_shift_ff   <= fbpa_pkg::SHIFT_RESET;
         cfg_count_ff   <= fbpa_pkg::COUNT_RESET;
         pool_base_ff   <= fbpa_pkg::BASE_RESET;
         pool_shift_ff  <= fbpa_pkg::SHIFT_RESET;
         pool_count_ff  <= fbpa_pkg::COUNT_RESET;
         pool_region_ff <= fbpa_pkg::DATA_W'(fbpa_pkg::COUNT_RESET) << fbpa_pkg::SHIFT_RESET;
         pool_mask_ff   <= (fbpa_pkg::DATA_W'(1) << fbpa_pkg::SHIFT_RESET) - 1'b1;
         head_ff        <= NULL_IDX;
         init_ff        <= 1'b0;
         walk_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               fbpa_pkg::CSR_BASE:  cfg_base_ff  <= csr_write_data;
               fbpa_pkg::CSR_SHIFT: cfg_shift_ff <= csr_write_data[fbpa_pkg::SHIFT_W-1:0];
               fbpa_pkg::CSR_COUNT: cfg_count_ff <= csr_write_data[fbpa_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.commit) begin
            head_ff      <= head_in;
            init_ff      <= init_in;
            walk_cnt_ff  <= '0;
            rsp_valid_ff <= 1'b1;
            if (init_go) begin
               pool_base_ff   <= cfg_base_ff;
               pool_shift_ff  <= cfg_shift_ff;
               pool_count_ff  <= cfg_count_ff;
               pool_region_ff <= fbpa_pkg::DATA_W'(cfg_count_ff) << cfg_shift_ff;
               pool_mask_ff   <= (fbpa_pkg::DATA_W'(1) << cfg_shift_ff) - 1'b1;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.walk) begin
            walk_cnt_ff <= walk_cnt_ff + 1'b1;
         end
      end
   end

   // request latch and result payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_kind_ff    <= req_kind;
         req_address_ff <= req_address;
      end
      if (cmd.commit) begin
         rsp_status_ff  <= status_in;
         rsp_address_ff <= address_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_address_ff;

   // head never carries an index past the null marker
   assert property (@(posedge clock) disable iff (reset) head_ff <= NULL_IDX)
      else $error("head index beyond null marker");

   // during the init sweep the pool is already live with block 0 at the head
   assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (init_ff && (head_ff == '0)))
      else $error("init sweep without live pool");

   // sweep stays inside the latched block count
   assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> (fbpa_pkg::DATA_W'(walk_cnt_ff) < fbpa_pkg::DATA_W'(pool_count_ff)))
      else $error("init sweep beyond block count");

   // a freed block becomes the head on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && push) |=> (head_ff == $past(block_index[IDX_W-1:0])))
      else $error("freed block not pushed");

endmodule

// File: hw/rtl/fixed_block_pool_allocator_unit.sv
// fixed_block_pool_allocator_unit: top level joining fbpa_ctrl and fbpa_datapath, uses fbpa_pkg
// each request is latched, then its result enters the result register once that register is free
// a new request is taken only once the previous one has committed and, for an init, has swept
// the link memory through its single write port, one link entry a cycle
// reset: synchronous, active high; pool uninitialised, free list empty, registers at 0 / 3 / 1
// the link memory is not cleared at reset, init writes every entry it later reads

module fixed_block_pool_allocator_unit #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fbpa_pkg::KIND_W-1:0]       req_kind,
   input  logic [fbpa_pkg::DATA_W-1:0]       req_address,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fbpa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [fbpa_pkg::DATA_W-1:0]       rsp_block_address,
   // configuration write port
   input  logic                              csr_write_enable,
   input  logic [fbpa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fbpa_pkg::DATA_W-1:0]       csr_write_data
);

   // command and status between sequencer and datapath
   fbpa_pkg::cmd_type cmd;
   fbpa_pkg::sts_type sts;

   // sequencer: idle, execute, init sweep
   // a new request is taken in idle even while the previous result still waits
   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: the link memory read port always follows the head, so the
   // successor of the head block is registered in the cycle after any head update
   // and an alloc is a single read-modify-write of the free list
   fbpa_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_kind),
      .req_address       (req_address),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address)
   );

endmodule

// File: verif/tb_fixed_block_pool_allocator_unit.sv
// testbench for fixed_block_pool_allocator_unit: a predicting scoreboard checks every result transfer
// against its own model of the free list under random stimulus, idling and back-pressure
// depends on fbpa_pkg and the allocator rtl only
`timescale 1ns / 100ps

module tb_fixed_block_pool_allocator_unit;

   localparam int DATA_W      = fbpa_pkg::DATA_W;
   localparam int KIND_W      = fbpa_pkg::KIND_W;
   localparam int STATUS_W    = fbpa_pkg::STATUS_W;
   localparam int SHIFT_W     = fbpa_pkg::SHIFT_W;
   localparam int COUNT_W     = fbpa_pkg::COUNT_W;
   localparam int CSR_INDEX_W = fbpa_pkg::CSR_INDEX_W;

   localparam int POOL_SLOTS     = 256;   // depth of the link memory, also the null marker
   localparam int SETTLE_CYCLES  = 4;     // quiet cycles before a register write and at the end
   localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transfer on either channel
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
   localparam int SESSION_ITEMS  = 95;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   block_address;
   } pool_result_type;

   // predicts the allocator and holds the results still owed by the block
   class pool_scoreboard_type;
      logic [DATA_W-1:0]  reg_base, pool_base;
      logic [SHIFT_W-1:0] reg_shift, pool_shift;
      logic [COUNT_W-1:0] reg_count, pool_count;
      int                 link_of[POOL_SLOTS];
      int                 head;
      bit                 live;
      pool_result_type    owed[$];
      logic [DATA_W-1:0]  held_blocks[$];  // handed out and not yet returned, feeds the stimulus
      int                 errors, checked;
      int                 kind_seen[4];
      int                 status_seen[8];

      function new();
         reg_base   = fbpa_pkg::BASE_RESET;
         reg_shift  = fbpa_pkg::SHIFT_RESET;
         reg_count  = fbpa_pkg::COUNT_RESET;
         pool_base  = fbpa_pkg::BASE_RESET;
         pool_shift = fbpa_pkg::SHIFT_RESET;
         pool_count = fbpa_pkg::COUNT_RESET;
         foreach (link_of[i]) link_of[i] = 0;
         head = POOL_SLOTS;
         live = 1'b0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [DATA_W-1:0] value);
         case (index)
            fbpa_pkg::CSR_BASE:  reg_base  = value;
            fbpa_pkg::CSR_SHIFT: reg_shift = value[SHIFT_W-1:0];
            fbpa_pkg::CSR_COUNT: reg_count = value[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // runs one accepted request through the model and queues its result
      function void note_request(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] address);
         pool_result_type   outcome;
         logic [DATA_W-1:0] offset, region, size_mask;
         int                slot;
         outcome.status        = fbpa_pkg::STATUS_OK;
         outcome.block_address = '0;
         kind_seen[kind]++;
         if (kind == fbpa_pkg::KIND_INIT) begin
            if (reg_count == 0 || reg_count > POOL_SLOTS) begin
               outcome.status = fbpa_pkg::STATUS_RANGE;
            end else if (reg_shift < fbpa_pkg::SHIFT_MIN || reg_shift > fbpa_pkg::SHIFT_MAX) begin
               outcome.status = fbpa_pkg::STATUS_ALIGN;
            end else begin
               pool_base  = reg_base;
               pool_shift = reg_shift;
               pool_count = reg_count;
               for (int i = 0; i < pool_count; i++) link_of[i] = i + 1;
               link_of[pool_count - 1] = POOL_SLOTS;
               head = 0;
               live = 1'b1;
               held_blocks.delete();
            end
         end else if (!live) begin
            outcome.status = fbpa_pkg::STATUS_UNINIT;
         end else if (kind == fbpa_pkg::KIND_ALLOC) begin
            if (head >= POOL_SLOTS) begin
               outcome.status = fbpa_pkg::STATUS_EMPTY;
            end else begin
               outcome.block_address = pool_base + (DATA_W'(head) << pool_shift);
               held_blocks.push_back(outcome.block_address);
               head = (link_of[head] > POOL_SLOTS) ? POOL_SLOTS : link_of[head];
            end
         end else if (kind == fbpa_pkg::KIND_FREE) begin
            offset    = address - pool_base;
            region    = DATA_W'(pool_count) << pool_shift;
            size_mask = (DATA_W'(1) << pool_shift) - 1;
            if (offset >= region) begin
               outcome.status = fbpa_pkg::STATUS_RANGE;
            end else if ((offset & size_mask) != 0) begin
               outcome.status = fbpa_pkg::STATUS_ALIGN;
            end else begin
               slot = int'(offset >> pool_shift);
               link_of[slot] = head;
               head = slot;
               for (int i = 0; i < held_blocks.size(); i++) begin
                  if (held_blocks[i] == address) begin
                     held_blocks.delete(i);
                     break;
                  end
               end
            end
         end else begin
            live = 1'b0;
            head = POOL_SLOTS;
            held_blocks.delete();
         end
         status_seen[outcome.status]++;
         owed.push_back(outcome);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] block_address);
         pool_result_type want;
         if (owed.size() == 0) begin
            $display("%0t: result transfer with nothing expected, status %0d address %h",
                     $time, status, block_address);
            errors++;
            return;
         end
         want = owed.pop_front();
         checked++;
         if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
            errors++;
         end
         if (block_address !== want.block_address) begin
            $display("%0t: block address mismatch, expected %h, actual %h",
                     $time, want.block_address, block_address);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [KIND_W-1:0]      req_kind         = fbpa_pkg::KIND_INIT;
   logic [DATA_W-1:0]      req_address      = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [DATA_W-1:0]      rsp_block_address;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = fbpa_pkg::CSR_BASE;
   logic [DATA_W-1:0]      csr_write_data   = '0;

   pool_scoreboard_type sb;
   int             sender_idle_pct   = 26;
   int             receiver_idle_pct = 50;
   bit             stall_kick        = 1'b0;  // toggled by the stimulus to ask for a long hold-off
   bit             stall_kick_seen   = 1'b0;
   int             hold_left         = 0;
   int             quiet_cycles      = 0;

   fixed_block_pool_allocator_unit #(
      .MAX_BLOCKS(POOL_SLOTS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side: check each transfer, then decide ready for the next edge
   // a long hold-off is counted here so the sender keeps offering meanwhile
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_status, rsp_block_address);
      end
      if (stall_kick != stall_kick_seen) begin
         stall_kick_seen = stall_kick;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // watchdog: ends a hung run once neither channel has moved for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, sb.pending());
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one request, with random idle cycles in front, and hold it until the transfer
   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] address);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_address <= address;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(kind, address);
   endtask

   // sender pauses until every owed result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      sb.write_register(index, value);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // registers are only written with the block idle; unused upper data bits are random
   task automatic set_pool_config(input logic [DATA_W-1:0] base,
                                  input logic [SHIFT_W-1:0] shift,
                                  input logic [COUNT_W-1:0] count);
      logic [DATA_W-1:0] word;
      wait_for_results();
      write_csr(fbpa_pkg::CSR_BASE, base);
      word = $urandom;
      word[SHIFT_W-1:0] = shift;
      write_csr(fbpa_pkg::CSR_SHIFT, word);
      word = $urandom;
      word[COUNT_W-1:0] = count;
      write_csr(fbpa_pkg::CSR_COUNT, word);
   endtask

   // one pool lifetime: optional rejected init, a good init, then mostly well-formed traffic
   task automatic run_session(input int items, input logic [DATA_W-1:0] base,
                              input logic [SHIFT_W-1:0] shift, input logic [COUNT_W-1:0] count);
      logic [DATA_W-1:0]  size, block;
      logic [SHIFT_W-1:0] bad_shift;
      logic [COUNT_W-1:0] bad_count;
      int                 pick, slot;
      if ($urandom_range(7) == 0) begin
         bad_shift = shift;
         bad_count = count;
         if ($urandom_range(1)) begin
            bad_count = $urandom_range(1) ? COUNT_W'(0) : COUNT_W'($urandom_range(257, 511));
         end else begin
            bad_shift = $urandom_range(1) ? SHIFT_W'($urandom_range(2))
                                          : SHIFT_W'($urandom_range(13, 15));
         end
         set_pool_config($urandom, bad_shift, bad_count);
         send_request(fbpa_pkg::KIND_INIT, $urandom);
      end
      set_pool_config(base, shift, count);
      send_request(fbpa_pkg::KIND_INIT, $urandom);
      for (int n = 1; n < items; n++) begin
         // halfway through, let the pipeline run dry once
         if (n == items / 2) wait_for_results();
         size = DATA_W'(1) << sb.pool_shift;
         slot = $urandom_range(sb.pool_count - 1);
         pick = $urandom_range(99);
         if (!sb.live && pick < 80) begin
            send_request(fbpa_pkg::KIND_INIT, $urandom);
         end else if (pick < 42 || (pick < 76 && sb.held_blocks.size() == 0)) begin
            send_request(fbpa_pkg::KIND_ALLOC, $urandom);
         end else if (pick < 76) begin
            send_request(fbpa_pkg::KIND_FREE,
                         sb.held_blocks[$urandom_range(sb.held_blocks.size() - 1)]);
         end else if (pick < 83) begin
            // any block of the region, often one that is already free
            send_request(fbpa_pkg::KIND_FREE, sb.pool_base + (DATA_W'(slot) << sb.pool_shift));
         end else if (pick < 88) begin
            block = sb.pool_base + (DATA_W'(slot) << sb.pool_shift);
            send_request(fbpa_pkg::KIND_FREE, block + DATA_W'($urandom_range(1, size - 1)));
         end else if (pick < 95) begin
            case ($urandom_range(2))
               0: block = sb.pool_base + (DATA_W'(sb.pool_count) << sb.pool_shift)
                          + (DATA_W'(slot) << sb.pool_shift);
               1: block = sb.pool_base - size;
               default: block = $urandom;
            endcase
            send_request(fbpa_pkg::KIND_FREE, block);
         end else if (pick < 98) begin
            send_request(fbpa_pkg::KIND_DESTROY, $urandom);
         end else begin
            send_request(fbpa_pkg::KIND_INIT, $urandom);
         end
      end
   endtask

   initial begin
      logic [DATA_W-1:0]  base;
      logic [SHIFT_W-1:0] shift;
      logic [COUNT_W-1:0] count;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: use before init, rejected inits, a wrapping pool of four blocks
      send_request(fbpa_pkg::KIND_ALLOC, '0);
      send_request(fbpa_pkg::KIND_FREE, '0);
      send_request(fbpa_pkg::KIND_DESTROY, '1);
      set_pool_config('0, fbpa_pkg::SHIFT_MIN, 9'd0);
      send_request(fbpa_pkg::KIND_INIT, '0);
      set_pool_config('0, fbpa_pkg::SHIFT_MIN, 9'd257);
      send_request(fbpa_pkg::KIND_INIT, '0);
      set_pool_config('0, 4'd2, 9'd4);
      send_request(fbpa_pkg::KIND_INIT, '0);
      set_pool_config('0, 4'd13, 9'd4);
      send_request(fbpa_pkg::KIND_INIT, '0);
      set_pool_config(32'hFFFF_FFF0, fbpa_pkg::SHIFT_MIN, 9'd4);
      send_request(fbpa_pkg::KIND_INIT, '0);
      // drain the pool past empty, addresses wrap through zero
      repeat (5) send_request(fbpa_pkg::KIND_ALLOC, '0);
      send_request(fbpa_pkg::KIND_FREE, 32'hFFFF_FFE8);   // below the base
      send_request(fbpa_pkg::KIND_FREE, 32'hFFFF_FFF4);   // inside a block
      send_request(fbpa_pkg::KIND_FREE, 32'h0000_0010);   // first byte past the region
      send_request(fbpa_pkg::KIND_FREE, 32'h0000_0008);
      send_request(fbpa_pkg::KIND_FREE, 32'h0000_0008);   // double free, pushed again
      repeat (2) send_request(fbpa_pkg::KIND_ALLOC, '0);
      // rejected init on a live pool leaves it alone
      set_pool_config('0, 4'd0, 9'd0);
      send_request(fbpa_pkg::KIND_INIT, '0);
      send_request(fbpa_pkg::KIND_ALLOC, '0);
      // rebuild a live pool, then tear it down
      set_pool_config(32'h8000_0000, fbpa_pkg::SHIFT_MAX, 9'd2);
      send_request(fbpa_pkg::KIND_INIT, '0);
      send_request(fbpa_pkg::KIND_DESTROY, '0);
      send_request(fbpa_pkg::KIND_ALLOC, '0);

      // random: receiver-heavy idling, then sender-heavy, then none
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct   = (phase == 0) ? 26 : (phase == 1) ? 50 : 0;
         receiver_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 26 : 0;
         for (int s = 0; s < 7; s++) begin
            if (phase == 0 && s == 0) begin
               base  = 32'hFFF8_0000;   // largest region, wraps past the top of memory
               shift = fbpa_pkg::SHIFT_MAX;
               count = COUNT_W'(POOL_SLOTS);
            end else if (phase == 0 && s == 1) begin
               base  = '0;
               shift = fbpa_pkg::SHIFT_MIN;
               count = 9'd1;
            end else if (phase == 1 && s == 0) begin
               base  = '1;
               shift = fbpa_pkg::SHIFT_MIN;
               count = COUNT_W'(POOL_SLOTS);
            end else begin
               base  = ($urandom_range(3) == 0) ? DATA_W'(0) : DATA_W'($urandom);
               pick_shift: begin
                  case ($urandom_range(3))
                     0: shift = fbpa_pkg::SHIFT_MIN;
                     1: shift = fbpa_pkg::SHIFT_MAX;
                     default: shift = SHIFT_W'($urandom_range(fbpa_pkg::SHIFT_MIN,
                                                               fbpa_pkg::SHIFT_MAX));
                  endcase
               end
               count = ($urandom_range(9) == 0) ? COUNT_W'(POOL_SLOTS)
                                                : COUNT_W'($urandom_range(1, 16));
            end
            // with no idling, drain first, then hold the result side off so the block backs up
            if (phase == 2 && s == 0) begin
               wait_for_results();
               stall_kick = ~stall_kick;
            end
            run_session(SESSION_ITEMS, base, shift, count);
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("requests sent: %0d init, %0d alloc, %0d free, %0d destroy; %0d results checked",
               sb.kind_seen[fbpa_pkg::KIND_INIT], sb.kind_seen[fbpa_pkg::KIND_ALLOC],
               sb.kind_seen[fbpa_pkg::KIND_FREE], sb.kind_seen[fbpa_pkg::KIND_DESTROY],
               sb.checked);
      $display("outcomes: %0d ok, %0d empty, %0d out of range, %0d misaligned, %0d uninitialised",
               sb.status_seen[fbpa_pkg::STATUS_OK], sb.status_seen[fbpa_pkg::STATUS_EMPTY],
               sb.status_seen[fbpa_pkg::STATUS_RANGE], sb.status_seen[fbpa_pkg::STATUS_ALIGN],
               sb.status_seen[fbpa_pkg::STATUS_UNINIT]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
